[design/clock_mux_divider_rate_search_assert.svh]
`ifndef CLOCK_MUX_DIVIDER_RATE_SEARCH_ASSERT_SVH
`define CLOCK_MUX_DIVIDER_RATE_SEARCH_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CMDRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cmdrs: implication check failed");

// Next-cycle implication, checked out of reset.
`define CMDRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cmdrs: next-cycle check failed");

`endif

[design/cmdrs_pkg.sv]
package cmdrs_pkg;

  localparam int RATE_W    = 31;
  localparam int RATE_REGS = 4;
  localparam int MUX_W     = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [RATE_W-1:0] NO_FIT = {RATE_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROUND_DOWN    = 3'd0,
    REG_MAX_DIVIDER   = 3'd1,
    REG_HAS_MUX       = 3'd2,
    REG_PARENT_RATE_0 = 3'd3,
    REG_PARENT_RATE_1 = 3'd4,
    REG_PARENT_RATE_2 = 3'd5,
    REG_PARENT_RATE_3 = 3'd6
  } cfg_reg_e;

  // controller -> datapath
  typedef struct packed {
    logic clear;      // load target, reset counters and best fit
    logic start_div;  // divide current parent rate by current divider
    logic update;     // compare quotient, keep it if strictly closer
    logic step_div;   // next divider
    logic step_par;   // next parent, divider back to 1
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rate_zero;
    logic div_done;
    logic d_last;
    logic p_last;
  } ctrl_sts_t;

endpackage

[design/cmdrs_div.sv]
`include "clock_mux_divider_rate_search_assert.svh"

module cmdrs_div
  import cmdrs_pkg::*;
#(
  parameter int DW = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RATE_W-1:0] dividend_i,
  input  logic [DW-1:0]     divisor_i,
  output logic              done_o,
  output logic [RATE_W-1:0] quotient_o
);

  localparam int CW = $clog2(RATE_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DW-1:0]     rem_q, rem_d;
  logic [DW-1:0]     dvs_q, dvs_d;
  logic [RATE_W-1:0] quo_q, quo_d;

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[RATE_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(RATE_W - 1);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_d = {quo_q[RATE_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  `CMDRS_ASSERT_NXT(a_div_start_runs, start_i, busy_q)
  `CMDRS_ASSERT_IMP(a_div_rem_bound, done_q && (dvs_q != '0), rem_q < dvs_q)

endmodule

[design/cmdrs_dp.sv]
module cmdrs_dp
  import cmdrs_pkg::*;
#(
  parameter int NUM_PARENTS    = 4,
  parameter int DIV_FIELD_BITS = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ctrl_cmd_t                 cmd_i,
  output ctrl_sts_t                 sts_o,
  input  logic [RATE_W-1:0]         target_rate_i,
  input  logic                      round_down_i,
  input  logic [6:0]                max_divider_i,
  input  logic                      has_mux_i,
  input  logic [RATE_W-1:0]         parent_rate_i [RATE_REGS],
  output logic                      found_o,
  output logic [MUX_W-1:0]          mux_select_o,
  output logic [DIV_FIELD_BITS-1:0] div_code_o,
  output logic                      write_mux_o,
  output logic [RATE_W-1:0]         achieved_rate_o
);

  localparam int DW   = DIV_FIELD_BITS + 1;
  localparam int CAP  = 1 << DIV_FIELD_BITS;
  localparam int SCAN = (NUM_PARENTS < RATE_REGS) ? NUM_PARENTS : RATE_REGS;

  logic [RATE_W-1:0] target_q;
  logic [MUX_W-1:0]  p_q;
  logic [DW-1:0]     d_q;
  logic [RATE_W-1:0] best_diff_q;
  logic [MUX_W-1:0]  best_mux_q;
  logic [DW-1:0]     best_div_q;
  logic [RATE_W-1:0] best_rate_q;

  logic [DW-1:0]     maxd;
  logic [RATE_W-1:0] rate_sel;
  logic              div_done;
  logic [RATE_W-1:0] cur;
  logic              over;
  logic [RATE_W-1:0] cur_dist;
  logic              better;
  logic              found;
  logic [DW-1:0]     code_full;

  // divider limit: 0 acts as 1, saturate at the field capacity
  always_comb begin
    if (max_divider_i == '0) begin
      maxd = DW'(1);
    end else if (int'(max_divider_i) > CAP) begin
      maxd = DW'(CAP);
    end else begin
      maxd = DW'(max_divider_i);
    end
  end

  assign rate_sel = parent_rate_i[p_q];

  cmdrs_div #(
    .DW(DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .dividend_i (rate_sel),
    .divisor_i  (d_q),
    .done_o     (div_done),
    .quotient_o (cur)
  );

  assign over     = cur > target_q;
  assign cur_dist = over ? (cur - target_q) : (target_q - cur);
  assign better   = !(round_down_i && over) && (cur_dist < best_diff_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q         <= '0;
      d_q         <= DW'(1);
      best_diff_q <= NO_FIT;
    end else begin
      if (cmd_i.clear) begin
        p_q         <= '0;
        d_q         <= DW'(1);
        best_diff_q <= NO_FIT;
      end else begin
        if (cmd_i.update && better) begin
          best_diff_q <= cur_dist;
        end
        if (cmd_i.step_par) begin
          p_q <= p_q + 1'b1;
          d_q <= DW'(1);
        end else if (cmd_i.step_div) begin
          d_q <= d_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      target_q    <= target_rate_i;
      best_mux_q  <= '0;
      best_div_q  <= DW'(1);
      best_rate_q <= '0;
    end else if (cmd_i.update && better) begin
      best_mux_q  <= p_q;
      best_div_q  <= d_q;
      best_rate_q <= cur;
    end
  end

  assign sts_o.rate_zero = (rate_sel == '0);
  assign sts_o.div_done  = div_done;
  assign sts_o.d_last    = (d_q == maxd);
  assign sts_o.p_last    = (p_q == MUX_W'(SCAN - 1));

  assign found     = (best_diff_q != NO_FIT);
  assign code_full = best_div_q - 1'b1;

  assign found_o         = found;
  assign mux_select_o    = found ? best_mux_q : '0;
  assign div_code_o      = found ? code_full[DIV_FIELD_BITS-1:0] : '0;
  assign write_mux_o     = found & has_mux_i;
  assign achieved_rate_o = found ? best_rate_q : '0;

endmodule

[design/cmdrs_ctrl.sv]
`include "clock_mux_divider_rate_search_assert.svh"

module cmdrs_ctrl
  import cmdrs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output logic      done_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_DIV   = 5'b00100,
    S_EVAL  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.clear = 1'b1;
          state_d     = S_SETUP;
        end
      end
      S_SETUP: begin
        if (sts_i.rate_zero) begin
          // absent source: skip all its dividers
          if (sts_i.p_last) begin
            state_d = S_DONE;
          end else begin
            cmd_o.step_par = 1'b1;
          end
        end else begin
          cmd_o.start_div = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.update = 1'b1;
        if (!sts_i.d_last) begin
          cmd_o.step_div = 1'b1;
          state_d        = S_SETUP;
        end else if (!sts_i.p_last) begin
          cmd_o.step_par = 1'b1;
          state_d        = S_SETUP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  `CMDRS_ASSERT_NXT(a_ctrl_accept_busy, start_i && !busy_o, busy_o && !done_o)
  `CMDRS_ASSERT_NXT(a_ctrl_done_pulse, done_o, !done_o && !busy_o)
  `CMDRS_ASSERT_IMP(a_ctrl_no_div_on_zero, cmd_o.start_div, !sts_i.rate_zero)

endmodule

[design/clock_mux_divider_rate_search.sv]
// Channel   | Direction | Ports                                     | Handshake
// ----------+-----------+-------------------------------------------+----------------------------
// request   | in        | start_i, target_rate_i                    | taken when start_i & !busy_o
// result    | out       | done_o, found_o, mux_select_o, div_code_o,| done_o high for one cycle
//           |           | write_mux_o, achieved_rate_o              |
// config    | in        | cfg_valid_i, cfg_index_i, cfg_data_i,     | written when valid & ready
//           |           | cfg_ready_o                               | (ready is always high)
//
// Sequencing: one item at a time. Each divider tried on a present source goes through
//   setup, the shared bit-serial divider, its done strobe and the compare; an absent
//   source is skipped from setup. An item walks every present source over dividers
//   1 to max_div, capped at the divider field's capacity.
// Reset: rst_ni is asynchronous, active low; registers return to round_down 0,
//   max_divider 8, has_mux 1, all parent rates 0.
// Stalls: the receiver cannot stall; the done strobe is shown for exactly one cycle.
module clock_mux_divider_rate_search
  import cmdrs_pkg::*;
#(
  parameter int NUM_PARENTS    = 4,
  parameter int DIV_FIELD_BITS = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request
  input  logic                      start_i,
  input  logic [RATE_W-1:0]         target_rate_i,
  output logic                      busy_o,
  // result
  output logic                      done_o,
  output logic                      found_o,
  output logic [MUX_W-1:0]          mux_select_o,
  output logic [DIV_FIELD_BITS-1:0] div_code_o,
  output logic                      write_mux_o,
  output logic [RATE_W-1:0]         achieved_rate_o,
  // configuration
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [RATE_W-1:0]         cfg_data_i
);

  // configuration registers
  logic              round_down_q;
  logic [6:0]        max_divider_q;
  logic              has_mux_q;
  logic [RATE_W-1:0] parent_rate_q [RATE_REGS];

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // writes are only expected while idle, so the port never back-pressures
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_down_q  <= 1'b0;
      max_divider_q <= 7'd8;
      has_mux_q     <= 1'b1;
      for (int i = 0; i < RATE_REGS; i++) begin
        parent_rate_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ROUND_DOWN:    round_down_q     <= cfg_data_i[0];
        REG_MAX_DIVIDER:   max_divider_q    <= cfg_data_i[6:0];
        REG_HAS_MUX:       has_mux_q        <= cfg_data_i[0];
        REG_PARENT_RATE_0: parent_rate_q[0] <= cfg_data_i;
        REG_PARENT_RATE_1: parent_rate_q[1] <= cfg_data_i;
        REG_PARENT_RATE_2: parent_rate_q[2] <= cfg_data_i;
        REG_PARENT_RATE_3: parent_rate_q[3] <= cfg_data_i;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // sequencer: walks sources, then dividers, in ascending order
  cmdrs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  // datapath: shared divider, distance compare, best-fit registers
  cmdrs_dp #(
    .NUM_PARENTS    (NUM_PARENTS),
    .DIV_FIELD_BITS (DIV_FIELD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .target_rate_i   (target_rate_i),
    .round_down_i    (round_down_q),
    .max_divider_i   (max_divider_q),
    .has_mux_i       (has_mux_q),
    .parent_rate_i   (parent_rate_q),
    .found_o         (found_o),
    .mux_select_o    (mux_select_o),
    .div_code_o      (div_code_o),
    .write_mux_o     (write_mux_o),
    .achieved_rate_o (achieved_rate_o)
  );

endmodule

[dv/clock_mux_divider_rate_search_tb.sv]
module clock_mux_divider_rate_search_tb;
  import cmdrs_pkg::*;

  localparam int NUM_PARENTS    = 4;
  localparam int DIV_FIELD_BITS = 6;
  localparam int DIV_CAP        = 1 << DIV_FIELD_BITS;

  localparam logic [RATE_W-1:0]    RATE_MAX     = {RATE_W{1'b1}};
  // distance that marks "nothing qualified yet"; a candidate this far never wins
  localparam logic [31:0]          NO_FIT_DIST  = {1'b0, NO_FIT};
  // index past the register map; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  // The worst legal item has four sources and 64 dividers. The run keeps those
  // rare; this limit is many times the length of a typical run.
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic                      found;
    logic [MUX_W-1:0]          mux;
    logic [DIV_FIELD_BITS-1:0] div_code;
    logic                      write_mux;
    logic [RATE_W-1:0]         rate;
  } fit_t;

  logic                      clk_i;
  logic                      rst_ni          = 1'b0;
  logic                      start_i         = 1'b0;
  logic [RATE_W-1:0]         target_rate_i   = '0;
  logic                      busy_o;
  logic                      done_o;
  logic                      found_o;
  logic [MUX_W-1:0]          mux_select_o;
  logic [DIV_FIELD_BITS-1:0] div_code_o;
  logic                      write_mux_o;
  logic [RATE_W-1:0]         achieved_rate_o;
  logic                      cfg_valid_i     = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i     = '0;
  logic [RATE_W-1:0]         cfg_data_i      = '0;

  // Local copy of the register file, updated on each accepted write.
  logic              cfg_round_down = 1'b0;
  logic [6:0]        cfg_max_div    = 7'd8;
  logic              cfg_has_mux    = 1'b1;
  logic [RATE_W-1:0] cfg_rate [RATE_REGS];

  fit_t expected_fits [$];

  int errors           = 0;
  int items_sent       = 0;
  int results_checked  = 0;
  int no_fit_seen      = 0;
  int round_down_items = 0;
  int reg_writes       = 0;
  int cycle_count      = 0;

  clock_mux_divider_rate_search #(
    .NUM_PARENTS   (NUM_PARENTS),
    .DIV_FIELD_BITS(DIV_FIELD_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .target_rate_i  (target_rate_i),
    .busy_o         (busy_o),
    .done_o         (done_o),
    .found_o        (found_o),
    .mux_select_o   (mux_select_o),
    .div_code_o     (div_code_o),
    .write_mux_o    (write_mux_o),
    .achieved_rate_o(achieved_rate_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  initial begin
    for (int i = 0; i < RATE_REGS; i++) cfg_rate[i] = '0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Divider limit as the block applies it: 0 acts as 1, anything past the
  // field's reach saturates.
  function automatic int eff_max_div();
    int lim;
    lim = int'(cfg_max_div);
    if (lim == 0) lim = 1;
    if (lim > DIV_CAP) lim = DIV_CAP;
    return lim;
  endfunction

  // Scan sources low to high, dividers low to high; only a strictly closer
  // quotient replaces the current pick, which keeps ties on the earliest one.
  function automatic fit_t best_fit(input logic [RATE_W-1:0] target);
    fit_t        fit;
    logic [31:0] best_dist;
    logic [31:0] tgt;
    logic [31:0] src;
    logic [31:0] cur;
    logic [31:0] delta;
    int          lim;
    int          p;
    int          d;
    fit       = '0;
    best_dist = NO_FIT_DIST;
    tgt       = {1'b0, target};
    lim       = eff_max_div();
    for (p = 0; p < NUM_PARENTS; p++) begin
      // sources without a rate register count as absent
      src = (p < RATE_REGS) ? {1'b0, cfg_rate[p]} : 32'd0;
      if (src == 32'd0) continue;
      for (d = 1; d <= lim; d++) begin
        cur = src / 32'(d);
        if (cfg_round_down) begin
          if (cur > tgt) continue;
          delta = tgt - cur;
        end else begin
          delta = (tgt >= cur) ? tgt - cur : cur - tgt;
        end
        if (delta < best_dist) begin
          best_dist    = delta;
          fit.mux      = p[MUX_W-1:0];
          fit.div_code = DIV_FIELD_BITS'(d - 1);
          fit.rate     = cur[RATE_W-1:0];
        end
      end
    end
    if (best_dist != NO_FIT_DIST) begin
      fit.found     = 1'b1;
      fit.write_mux = cfg_has_mux;
    end else begin
      // range error: every result field reads zero
      fit = '0;
    end
    return fit;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: done_o is sampled mid-cycle, away from the driving edge.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input fit_t want);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("%s: expected found=%0b mux=%0d div_code=%0d write_mux=%0b rate=%0d",
               what, want.found, want.mux, want.div_code, want.write_mux, want.rate);
      $display("  got found=%0b mux=%0d div_code=%0d write_mux=%0b rate=%0d",
               found_o, mux_select_o, div_code_o, write_mux_o, achieved_rate_o);
    end
  endtask

  always @(negedge clk_i) begin
    fit_t want;
    if (rst_ni && done_o) begin
      if (expected_fits.size() == 0) begin
        report_mismatch("result with no request outstanding", '0);
      end else begin
        want = expected_fits.pop_front();
        results_checked++;
        if (!want.found) no_fit_seen++;
        if (found_o !== want.found || mux_select_o !== want.mux ||
            div_code_o !== want.div_code || write_mux_o !== want.write_mux ||
            achieved_rate_o !== want.rate)
          report_mismatch($sformatf("item %0d mismatch", results_checked), want);
      end
    end
  end

  // Hard stop; counts every clock from time zero.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still outstanding",
             cycle_count, expected_fits.size());
    $display("clock_mux_divider_rate_search_tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task is entered and left just after a rising edge.
  // ---------------------------------------------------------------------------

  // Mostly back-to-back or short waits, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Start is held until the block takes it; busy_o is read mid-cycle so the
  // decision matches what the block sees at the next edge.
  task automatic request_rate(input logic [RATE_W-1:0] target, input int gap);
    repeat (gap) @(posedge clk_i);
    start_i       <= 1'b1;
    target_rate_i <= target;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    expected_fits.push_back(best_fit(target));
    items_sent++;
    if (cfg_round_down) round_down_items++;
    start_i       <= 1'b0;
    target_rate_i <= RATE_W'($urandom);  // junk while idle, must be ignored
    @(posedge clk_i);
  endtask

  // Idle point: every result back and the block not busy.
  task automatic drain();
    wait (expected_fits.size() == 0);
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    reg_writes++;
    case (idx)
      REG_ROUND_DOWN:    cfg_round_down = data[0];
      REG_MAX_DIVIDER:   cfg_max_div    = data[6:0];
      REG_HAS_MUX:       cfg_has_mux    = data[0];
      REG_PARENT_RATE_0,
      REG_PARENT_RATE_1,
      REG_PARENT_RATE_2,
      REG_PARENT_RATE_3: cfg_rate[idx - REG_PARENT_RATE_0] = data;
      default: ;         // unmapped index: dropped
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic rd, input logic [6:0] maxd, input logic mux,
                           input logic [RATE_W-1:0] r0, input logic [RATE_W-1:0] r1,
                           input logic [RATE_W-1:0] r2, input logic [RATE_W-1:0] r3);
    drain();
    write_reg(REG_ROUND_DOWN, RATE_W'(rd));
    write_reg(REG_MAX_DIVIDER, RATE_W'(maxd));
    write_reg(REG_HAS_MUX, RATE_W'(mux));
    write_reg(REG_PARENT_RATE_0, r0);
    write_reg(REG_PARENT_RATE_1, r1);
    write_reg(REG_PARENT_RATE_2, r2);
    write_reg(REG_PARENT_RATE_3, r3);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset no source has a rate: every request is a range error.
  task automatic test_no_source();
    request_rate('0, 0);
    request_rate(RATE_MAX, 0);
  endtask

  // Only source 0's rate is written, so the reset divider limit (8) and mux flag hold.
  task automatic test_reset_limits();
    drain();
    write_reg(REG_PARENT_RATE_0, 31'd1000);
    request_rate(31'd100, 0);   // best is the last allowed divider
    request_rate(RATE_MAX, 0);
  endtask

  // Full-scale rates and targets at both ends, all 64 dividers.
  task automatic test_nearest_extremes();
    configure(1'b0, 7'd64, 1'b1, RATE_MAX, 31'd1, 31'h5555_5555, 31'h2AAA_AAAA);
    request_rate('0, 0);
    request_rate(RATE_MAX, 0);
    request_rate(31'h4000_0000, 0);
    request_rate(31'd1, 0);
  endtask

  // A full-scale source against target 0 with one divider sits exactly on the
  // no-candidate mark and must not count as a fit.
  task automatic test_no_fit_mark();
    configure(1'b0, 7'd1, 1'b1, RATE_MAX, '0, '0, '0);
    request_rate('0, 0);
    request_rate(31'd1, 0);
  endtask

  // Round-down: quotients above the target are skipped; target 0 finds nothing.
  task automatic test_round_down();
    configure(1'b1, 7'd8, 1'b1, 31'd1000, 31'd3000, '0, '0);
    request_rate(31'd999, 0);
    request_rate('0, 0);
    request_rate(RATE_MAX, 0);
  endtask

  // Limit 0 acts as 1; 65 and 127 saturate to 64 rather than wrapping the code.
  task automatic test_divider_limits();
    logic [6:0] limits [5];
    limits = '{7'd0, 7'd1, 7'd64, 7'd65, 7'd127};
    configure(1'b0, 7'd8, 1'b1, 31'd1000, '0, '0, '0);
    foreach (limits[i]) begin
      drain();
      write_reg(REG_MAX_DIVIDER, RATE_W'(limits[i]));
      request_rate(31'd1, 0);
    end
  endtask

  // Equal sources, equal quotients from several dividers, and a target midway
  // between two quotients: the earliest candidate must stay.
  task automatic test_ties();
    configure(1'b0, 7'd8, 1'b1, 31'd600, 31'd600, 31'd300, 31'd5);
    request_rate(31'd300, 0);
    request_rate(31'd250, 0);
    request_rate(31'd1, 0);
  endtask

  // No mux field: write_mux stays low whether or not a fit is found.
  task automatic test_no_mux();
    configure(1'b0, 7'd8, 1'b0, 31'd600, '0, '0, '0);
    request_rate(31'd300, 0);
    drain();
    write_reg(REG_ROUND_DOWN, RATE_W'(1'b1));
    request_rate('0, 0);
  endtask

  task automatic test_unmapped_register();
    configure(1'b0, 7'd4, 1'b1, 31'd900, '0, '0, '0);
    write_reg(REG_UNMAPPED, RATE_MAX);
    request_rate(31'd450, 0);
  endtask

  // Mix of zero, tiny, full-scale, duplicated and random source rates.
  function automatic logic [RATE_W-1:0] pick_source(input int idx,
                                                    input logic [RATE_W-1:0] prev [RATE_REGS]);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r < 4) return RATE_W'($urandom_range(1, 300));
    if (r == 4) return RATE_MAX;
    if (r < 7 && idx > 0) return prev[$urandom_range(0, idx - 1)];
    return RATE_W'($urandom);
  endfunction

  // Half the draws aim on or next to a reachable quotient (random if that source has no rate).
  function automatic logic [RATE_W-1:0] pick_target();
    int          r;
    int          p;
    logic [31:0] near;
    logic [31:0] off;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      p = $urandom_range(0, RATE_REGS - 1);
      if (cfg_rate[p] == '0) return RATE_W'($urandom);
      near = {1'b0, cfg_rate[p]} / 32'($urandom_range(1, eff_max_div()));
      off  = 32'($urandom_range(0, 3));
      if ($urandom_range(0, 1) == 0)
        near = (near > off) ? near - off : 32'd0;
      else
        near = (near + off > {1'b0, RATE_MAX}) ? {1'b0, RATE_MAX} : near + off;
      return near[RATE_W-1:0];
    end
    if (r < 7) return RATE_W'($urandom);
    if (r == 7) return '0;
    if (r == 8) return RATE_MAX;
    return RATE_W'($urandom_range(0, 1000));
  endfunction

  // Random settings per sweep; divider limits past 12 get only two items
  // since each item then walks many dividers.
  task automatic test_random_sweeps();
    logic [RATE_W-1:0] rates [RATE_REGS];
    logic [6:0]        maxd;
    int                r;
    int                n;
    bit                burst;
    for (int sweep = 0; sweep < 8; sweep++) begin
      r = $urandom_range(0, 9);
      if (r < 7)       maxd = 7'($urandom_range(1, 12));
      else if (r == 7) maxd = 7'd0;
      else if (r == 8) maxd = 7'd64;
      else             maxd = 7'($urandom_range(65, 127));
      for (int i = 0; i < RATE_REGS; i++) rates[i] = pick_source(i, rates);
      configure(1'($urandom), maxd, 1'($urandom), rates[0], rates[1], rates[2], rates[3]);
      n     = (eff_max_div() > 12) ? 2 : 14;
      burst = ($urandom_range(0, 3) == 0);  // a stretch with no idling
      for (int i = 0; i < n; i++) begin
        request_rate(pick_target(), burst ? 0 : idle_gap());
        // now and then hold off until everything is back
        if ($urandom_range(0, 11) == 0) drain();
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_no_source();
    test_reset_limits();
    test_nearest_extremes();
    test_no_fit_mark();
    test_round_down();
    test_divider_limits();
    test_ties();
    test_no_mux();
    test_unmapped_register();
    test_random_sweeps();

    // all results back, then a quiet window to catch stray strobes
    wait (expected_fits.size() == 0);
    do @(negedge clk_i); while (busy_o);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_fits.size() != 0) begin
      errors++;
      $display("%0d results never arrived", expected_fits.size());
    end

    $display("searched %0d targets (%0d round-down), %0d results checked, %0d range errors",
             items_sent, round_down_items, results_checked, no_fit_seen);
    $display("%0d register writes, %0d mismatches, %0d cycles", reg_writes, errors, cycle_count);
    if (errors == 0)
      $display("clock_mux_divider_rate_search_tb passed");
    else
      $display("clock_mux_divider_rate_search_tb failed");
    $finish;
  end

endmodule
